@@ hw/rtl/hkf_pkg.sv @@
package hkf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;
	localparam int CFG_BITS  = 31;
	localparam int ANG_BITS  = 26;
	localparam int HEAD_BITS = 25;
	localparam int ACC_BITS  = 34;
	localparam int DIV_BITS  = WORD_BITS + FRAC_BITS;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [CFG_BITS-1:0] cfg_t;
	typedef logic signed [ANG_BITS-1:0] angle_t;
	typedef logic signed [HEAD_BITS-1:0] head_t;
	typedef logic signed [ACC_BITS-1:0] acc_t;
	typedef logic [1:0] mode_t;
	typedef logic [2:0] cfg_idx_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	localparam acc_t HALF_TURN = acc_t'(180 * (2 ** FRAC_BITS));
	localparam acc_t FULL_TURN = acc_t'(360 * (2 ** FRAC_BITS));

	localparam mode_t MODE_INIT    = 2'd0;
	localparam mode_t MODE_PREDICT = 2'd1;
	localparam mode_t MODE_COMPASS = 2'd2;
	localparam mode_t MODE_GPS     = 2'd3;

	localparam cfg_idx_t REG_HEAD_NOISE = 3'd0;
	localparam cfg_idx_t REG_RATE_NOISE = 3'd1;
	localparam cfg_idx_t REG_INIT_HVAR  = 3'd2;
	localparam cfg_idx_t REG_INIT_RVAR  = 3'd3;
	localparam cfg_idx_t REG_MIN_SPEED  = 3'd4;

	function automatic word_t sat_add(word_t a, word_t b);
		logic signed [WORD_BITS:0] s;
		s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
		if (s[WORD_BITS] != s[WORD_BITS-1])
			return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
		return word_t'(s[WORD_BITS-1:0]);
	endfunction

	// The negated operand saturates first, as a separate step.
	function automatic word_t sat_sub(word_t a, word_t m);
		word_t n;
		n = (m == WORD_MIN) ? WORD_MAX : word_t'(-m);
		return sat_add(a, n);
	endfunction

endpackage

@@ hw/rtl/hkf_if.sv @@
interface hkf_item_if import hkf_pkg::*; ();
	logic   valid;
	logic   ready;
	mode_t  mode;
	angle_t angle_in;
	word_t  rate_in;
	cfg_t   time_step;
	cfg_t   meas_variance;
	cfg_t   ground_speed;

	modport source(output valid, mode, angle_in, rate_in, time_step, meas_variance,
		ground_speed, input ready);
	modport sink(input valid, mode, angle_in, rate_in, time_step, meas_variance,
		ground_speed, output ready);
endinterface

interface hkf_result_if import hkf_pkg::*; ();
	logic  valid;
	logic  ready;
	head_t heading_out;
	word_t heading_rate_out;
	logic  is_initialized;
	logic  applied;

	modport source(output valid, heading_out, heading_rate_out, is_initialized, applied,
		input ready);
	modport sink(input valid, heading_out, heading_rate_out, is_initialized, applied,
		output ready);
endinterface

@@ hw/rtl/hkf_mul.sv @@
module hkf_mul import hkf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t a,
	input  word_t b,
	output logic  done,
	output word_t p
);
	localparam int MW = 2 * WORD_BITS + 1 - FRAC_BITS;
	localparam logic [MW-1:0] LIM = MW'(1) << (WORD_BITS - 1);

	logic [WORD_BITS-1:0]   ua, ub;
	logic [2*WORD_BITS-1:0] prod_s1;
	logic                   neg_s1, v_s1;
	logic [2*WORD_BITS:0]   rnd;
	logic [MW-1:0]          m;
	word_t                  res;
	word_t                  p_q;
	logic                   done_q;

	assign ua = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
	assign ub = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);

	// Round half away from zero on the magnitude, then saturate.
	always_comb begin
		rnd = {1'b0, prod_s1} + ((2*WORD_BITS+1)'(1) << (FRAC_BITS - 1));
		m   = MW'(rnd >> FRAC_BITS);
		if (neg_s1)
			res = (m > LIM) ? WORD_MIN : word_t'(-m[WORD_BITS-1:0]);
		else
			res = (m >= LIM) ? WORD_MAX : word_t'(m[WORD_BITS-1:0]);
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ua * ub;
		neg_s1  <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
		p_q     <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			done_q <= v_s1;
		end
	end

	assign done = done_q;
	assign p    = p_q;
endmodule

@@ hw/rtl/hkf_div.sv @@
module hkf_div import hkf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t num,
	input  word_t den,
	output logic  done,
	output word_t q
);
	localparam int CNT_BITS = $clog2(DIV_BITS + 1);
	localparam logic [DIV_BITS-1:0] LIM = DIV_BITS'(1) << (WORD_BITS - 1);

	logic [DIV_BITS-1:0]  dq_q;
	logic [WORD_BITS-1:0] rem_q;
	logic [WORD_BITS-1:0] den_q;
	logic [WORD_BITS-1:0] un;
	logic [WORD_BITS:0]   rem_sh, diff;
	logic                 ge;
	logic                 neg_q, busy_q, fin_q, done_q;
	logic [CNT_BITS-1:0]  cnt_q;
	word_t                q_q, res;

	assign un     = num[WORD_BITS-1] ? WORD_BITS'(-num) : WORD_BITS'(num);
	assign rem_sh = {rem_q, dq_q[DIV_BITS-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_comb begin
		if (neg_q)
			res = (dq_q > LIM) ? WORD_MIN : word_t'(-dq_q[WORD_BITS-1:0]);
		else
			res = (dq_q >= LIM) ? WORD_MAX : word_t'(dq_q[WORD_BITS-1:0]);
	end

	// One quotient bit per cycle; the quotient shifts in behind the dividend.
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= {un, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			den_q <= WORD_BITS'(den);
			neg_q <= num[WORD_BITS-1];
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIV_BITS-2:0], ge};
			rem_q <= ge ? diff[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
		end
		if (fin_q)
			q_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(DIV_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign q    = q_q;
endmodule

@@ hw/rtl/heading_kalman_filter_two_state.sv @@
// One item is in work at a time; the next input transfer can come in the same cycle as the
// result valid at the earliest, and a result held by the sink stalls completion.
// Each serial divide runs 48 steps.
// arst_n clears the estimate, covariance and initialized flag and loads the register defaults.
module heading_kalman_filter_two_state import hkf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	hkf_item_if.sink     item,
	hkf_result_if.source result,
	input  logic     cfg_we,
	input  cfg_idx_t cfg_index,
	input  cfg_t     cfg_data
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_MWAIT = 3'd2;
	localparam logic [2:0] ST_DWAIT = 3'd3;
	localparam logic [2:0] ST_WRAP  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	// Program steps; a multiply or divide step resumes at the next code.
	localparam logic [4:0] PC_DEC = 5'd0;
	localparam logic [4:0] PC_P0  = 5'd1;
	localparam logic [4:0] PC_P1  = 5'd2;
	localparam logic [4:0] PC_P2  = 5'd3;
	localparam logic [4:0] PC_P3  = 5'd4;
	localparam logic [4:0] PC_P4  = 5'd5;
	localparam logic [4:0] PC_P5  = 5'd6;
	localparam logic [4:0] PC_PH  = 5'd7;
	localparam logic [4:0] PC_M0  = 5'd8;
	localparam logic [4:0] PC_MY  = 5'd9;
	localparam logic [4:0] PC_M1  = 5'd10;
	localparam logic [4:0] PC_M2  = 5'd11;
	localparam logic [4:0] PC_M3  = 5'd12;
	localparam logic [4:0] PC_M4  = 5'd13;
	localparam logic [4:0] PC_MH  = 5'd14;
	localparam logic [4:0] PC_M5  = 5'd15;
	localparam logic [4:0] PC_M6  = 5'd16;
	localparam logic [4:0] PC_M7  = 5'd17;
	localparam logic [4:0] PC_M8  = 5'd18;
	localparam logic [4:0] PC_M9  = 5'd19;
	localparam logic [4:0] PC_M10 = 5'd20;
	localparam logic [4:0] PC_IH  = 5'd21;

	logic [2:0] state_q;
	logic [4:0] pc_q;
	logic [2:0] wk_q;
	logic       wneg_q;
	logic       init_q, applied_q, ov_q;

	cfg_t hpn_q, rpn_q, ihv_q, irv_q, minspd_q;

	head_t hd_q;
	word_t rt_q;
	word_t p_q [4];

	mode_t  mode_q;
	angle_t ang_q;
	word_t  rin_q;
	cfg_t   dt_q, var_q, spd_q;
	word_t  ta_q, tb_q, sv_q, y_q, k0_q, k1_q;
	acc_t   x_q;

	head_t res_hd_q;
	word_t res_rt_q;
	logic  res_init_q, res_app_q;

	logic  mul_start, mul_done, div_start, div_done;
	word_t mul_a, mul_b, mul_p, div_num, div_q;
	word_t dt_w, s_w;
	acc_t  wrap_in, fs, cand;
	logic  take;

	assign dt_w = word_t'({1'b0, dt_q});
	assign s_w  = sat_add(p_q[0], word_t'({1'b0, var_q}));

	always_comb begin
		mul_start = 1'b0;
		mul_a     = dt_w;
		mul_b     = p_q[2];
		div_start = 1'b0;
		div_num   = (pc_q == PC_M2) ? p_q[2] : p_q[0];
		if (state_q == ST_EXEC) begin
			case (pc_q)
				PC_P0: begin mul_start = 1'b1; mul_a = dt_w; mul_b = p_q[2]; end
				PC_P1: begin mul_start = 1'b1; mul_a = dt_w; mul_b = p_q[3]; end
				PC_P3: begin mul_start = 1'b1; mul_a = p_q[1]; mul_b = dt_w; end
				PC_P4: begin mul_start = 1'b1; mul_a = rt_q; mul_b = dt_w; end
				PC_M3: begin mul_start = 1'b1; mul_a = k0_q; mul_b = y_q; end
				PC_M5: begin mul_start = 1'b1; mul_a = k1_q; mul_b = y_q; end
				PC_M6: begin mul_start = 1'b1; mul_a = k1_q; mul_b = p_q[0]; end
				PC_M7: begin mul_start = 1'b1; mul_a = k0_q; mul_b = p_q[0]; end
				PC_M8: begin mul_start = 1'b1; mul_a = k1_q; mul_b = p_q[1]; end
				PC_M9: begin mul_start = 1'b1; mul_a = k0_q; mul_b = p_q[1]; end
				PC_M1, PC_M2: div_start = 1'b1;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (pc_q)
			PC_DEC:       wrap_in = acc_t'(ang_q);
			PC_M0:        wrap_in = acc_t'(ang_q) - acc_t'(hd_q);
			PC_P5, PC_M4: wrap_in = acc_t'(hd_q) + acc_t'(ta_q);
			default:      wrap_in = acc_t'(hd_q);
		endcase
	end

	// Wrap by whole turns: a binary search on the turn count, one bit per cycle.
	assign fs   = FULL_TURN <<< wk_q;
	assign cand = wneg_q ? (x_q + fs) : (x_q - fs);
	assign take = wneg_q ? (cand < HALF_TURN) : (cand > -HALF_TURN);

	hkf_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p)
	);

	hkf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(sv_q),
		.done(div_done), .q(div_q)
	);

	assign item.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			mode_q <= item.mode;
			ang_q  <= item.angle_in;
			rin_q  <= item.rate_in;
			dt_q   <= item.time_step;
			var_q  <= item.meas_variance;
			spd_q  <= item.ground_speed;
		end
		if (state_q == ST_MWAIT && mul_done)
			ta_q <= mul_p;
		if (state_q == ST_DWAIT && div_done) begin
			k1_q <= div_q;
			k0_q <= k1_q;
		end
		if (state_q == ST_EXEC) begin
			case (pc_q)
				PC_P1: tb_q <= ta_q;
				PC_M0: sv_q <= s_w;
				PC_MY: y_q  <= word_t'(x_q[WORD_BITS-1:0]);
				default: ;
			endcase
			if (pc_q == PC_DEC || pc_q == PC_P5 || pc_q == PC_M0 || pc_q == PC_M4) begin
				x_q    <= wrap_in;
				wneg_q <= wrap_in < -HALF_TURN;
			end
		end else if (state_q == ST_WRAP && take) begin
			x_q <= cand;
		end
		if (state_q == ST_DONE && (!ov_q || result.ready)) begin
			res_hd_q   <= init_q ? hd_q : '0;
			res_rt_q   <= init_q ? rt_q : '0;
			res_init_q <= init_q;
			res_app_q  <= applied_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_q      <= PC_DEC;
			wk_q      <= '0;
			init_q    <= 1'b0;
			applied_q <= 1'b0;
			ov_q      <= 1'b0;
			hd_q      <= '0;
			rt_q      <= '0;
			p_q[0]    <= '0;
			p_q[1]    <= '0;
			p_q[2]    <= '0;
			p_q[3]    <= '0;
			hpn_q     <= cfg_t'(655);
			rpn_q     <= cfg_t'(6554);
			ihv_q     <= cfg_t'(1638400);
			irv_q     <= cfg_t'(655360);
			minspd_q  <= cfg_t'(32768);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HEAD_NOISE: hpn_q    <= cfg_data;
					REG_RATE_NOISE: rpn_q    <= cfg_data;
					REG_INIT_HVAR:  ihv_q    <= cfg_data;
					REG_INIT_RVAR:  irv_q    <= cfg_data;
					REG_MIN_SPEED:  minspd_q <= cfg_data;
					default: ;
				endcase
			end

			// A completing item refills the output register; otherwise a transfer empties it.
			if (state_q == ST_DONE && (!ov_q || result.ready))
				ov_q <= 1'b1;
			else if (result.ready)
				ov_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						state_q <= ST_EXEC;
						pc_q    <= PC_DEC;
					end
				end
				ST_EXEC: begin
					unique case (pc_q)
						PC_DEC: begin
							if (mode_q == MODE_INIT) begin
								rt_q      <= rin_q;
								p_q[0]    <= word_t'({1'b0, ihv_q});
								p_q[1]    <= '0;
								p_q[2]    <= '0;
								p_q[3]    <= word_t'({1'b0, irv_q});
								init_q    <= 1'b1;
								applied_q <= 1'b1;
								wk_q      <= 3'd6;
								pc_q      <= PC_IH;
								state_q   <= ST_WRAP;
							end else if (init_q && mode_q == MODE_PREDICT) begin
								applied_q <= 1'b1;
								pc_q      <= PC_P0;
							end else if (init_q && (mode_q == MODE_COMPASS ||
								(mode_q == MODE_GPS && spd_q >= minspd_q))) begin
								applied_q <= 1'b1;
								pc_q      <= PC_M0;
							end else begin
								applied_q <= 1'b0;
								state_q   <= ST_DONE;
							end
						end
						PC_P2: begin
							p_q[0] <= sat_add(p_q[0], tb_q);
							p_q[1] <= sat_add(p_q[1], ta_q);
							p_q[2] <= sat_add(p_q[2], ta_q);
							p_q[3] <= sat_add(p_q[3], word_t'({1'b0, rpn_q}));
							pc_q   <= PC_P3;
						end
						PC_P4: begin
							p_q[0]  <= sat_add(sat_add(p_q[0], ta_q), word_t'({1'b0, hpn_q}));
							state_q <= ST_MWAIT;
						end
						PC_P5: begin
							if (rin_q != '0)
								rt_q <= rin_q;
							wk_q    <= 3'd6;
							pc_q    <= PC_PH;
							state_q <= ST_WRAP;
						end
						PC_PH, PC_IH: begin
							hd_q    <= head_t'(x_q[HEAD_BITS-1:0]);
							state_q <= ST_DONE;
						end
						PC_M0: begin
							// A nonpositive innovation variance leaves the state as it is.
							if (s_w <= 0) begin
								state_q <= ST_DONE;
							end else begin
								wk_q    <= 3'd6;
								pc_q    <= PC_MY;
								state_q <= ST_WRAP;
							end
						end
						PC_MY: pc_q <= PC_M1;
						PC_M1, PC_M2: state_q <= ST_DWAIT;
						PC_M4: begin
							wk_q    <= 3'd6;
							pc_q    <= PC_MH;
							state_q <= ST_WRAP;
						end
						PC_MH: begin
							hd_q <= head_t'(x_q[HEAD_BITS-1:0]);
							pc_q <= PC_M5;
						end
						PC_M6: begin
							rt_q    <= sat_add(rt_q, ta_q);
							state_q <= ST_MWAIT;
						end
						PC_M7: begin
							p_q[2]  <= sat_sub(p_q[2], ta_q);
							state_q <= ST_MWAIT;
						end
						PC_M8: begin
							p_q[0]  <= sat_sub(p_q[0], ta_q);
							state_q <= ST_MWAIT;
						end
						PC_M9: begin
							p_q[3]  <= sat_sub(p_q[3], ta_q);
							state_q <= ST_MWAIT;
						end
						PC_M10: begin
							p_q[1]  <= sat_sub(p_q[1], ta_q);
							state_q <= ST_DONE;
						end
						default: state_q <= ST_MWAIT;
					endcase
				end
				ST_MWAIT: begin
					if (mul_done) begin
						pc_q    <= pc_q + 5'd1;
						state_q <= ST_EXEC;
					end
				end
				ST_DWAIT: begin
					if (div_done) begin
						pc_q    <= pc_q + 5'd1;
						state_q <= ST_EXEC;
					end
				end
				ST_WRAP: begin
					wk_q <= wk_q - 3'd1;
					if (wk_q == '0)
						state_q <= ST_EXEC;
				end
				ST_DONE: begin
					if (!ov_q || result.ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid            = ov_q;
	assign result.heading_out      = res_hd_q;
	assign result.heading_rate_out = res_rt_q;
	assign result.is_initialized   = res_init_q;
	assign result.applied          = res_app_q;

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_t'(hd_q) <= HALF_TURN) && (acc_t'(hd_q) >= -HALF_TURN))
		else $error("heading estimate left the wrapped range");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the completion step");

	a_init_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(init_q))
		else $error("initialized flag cleared without reset");

	a_uninit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !res_init_q) |-> (res_hd_q == '0 && res_rt_q == '0))
		else $error("uninitialized result carries a nonzero estimate");
endmodule
